/* rtl/core/mhtm_pkg.sv */
// mhtm_pkg: shared types, codes and constants of the metric history monitor
// no dependencies; used by every module under rtl/core

package mhtm_pkg;

  localparam int SAMPLE_W              = 64;
  localparam int FILL_W                = 7;
  localparam int HIST_LEN_W            = 7;
  localparam int HISTORY_DEPTH_DEFAULT = 64;
  localparam int QUEUE_DEPTH           = 4;
  localparam int CFG_DATA_W            = 64;
  localparam int CFG_ADDR_W            = 6;

  // trend floor for the 5 percent band (1/20) and the reset history length
  localparam logic [SAMPLE_W-1:0]   TREND_FLOOR     = 64'd20;
  localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET  = 7'd64;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_THRESHOLD = 2'd1,
    STATUS_DISABLED  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TREND_STABLE     = 2'd0,
    TREND_INCREASING = 2'd1,
    TREND_DECREASING = 2'd2
  } trend_t;

  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_ENUM   = 2'd1,
    KIND_BOOL   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_MONITOR_ENABLE    = 3'd0,
    REG_VALUE_KIND        = 3'd1,
    REG_CHECK_LOW_ENABLE  = 3'd2,
    REG_CHECK_HIGH_ENABLE = 3'd3,
    REG_LOW_LIMIT         = 3'd4,
    REG_HIGH_LIMIT        = 3'd5,
    REG_HISTORY_LENGTH    = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic                  monitor_enable;
    logic [1:0]            value_kind;
    logic                  check_low_enable;
    logic                  check_high_enable;
    logic [SAMPLE_W-1:0]   low_limit;
    logic [SAMPLE_W-1:0]   high_limit;
    logic [HIST_LEN_W-1:0] history_length;
  } cfg_t;

  // control part of one queued transaction
  typedef struct packed {
    logic              wr_en;
    logic              need_trend;
    logic              c_two;
    status_t           status;
    logic [FILL_W-1:0] fill;
  } item_ctl_t;

  // queued transaction: sample, write address, two read addresses, control
  function automatic int item_width(input int depth);
    return SAMPLE_W + 3 * $clog2(depth) + $bits(item_ctl_t);
  endfunction

endpackage

/* rtl/core/mhtm_regs.sv */
// mhtm_regs: apb-style configuration register file
// depends on mhtm_pkg (cfg_t, register index codes, reset values)

module mhtm_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mhtm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mhtm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mhtm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output mhtm_pkg::cfg_t                      cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.monitor_enable    <= 1'b1;
      cfg.value_kind        <= mhtm_pkg::KIND_NUMBER;
      cfg.check_low_enable  <= 1'b0;
      cfg.check_high_enable <= 1'b0;
      cfg.low_limit         <= '0;
      cfg.high_limit        <= '1;
      cfg.history_length    <= mhtm_pkg::HIST_LEN_RESET;
    end else if (wr) begin
      unique case (idx)
        mhtm_pkg::REG_MONITOR_ENABLE:    cfg.monitor_enable    <= pwdata[0];
        mhtm_pkg::REG_VALUE_KIND:        cfg.value_kind        <= pwdata[1:0];
        mhtm_pkg::REG_CHECK_LOW_ENABLE:  cfg.check_low_enable  <= pwdata[0];
        mhtm_pkg::REG_CHECK_HIGH_ENABLE: cfg.check_high_enable <= pwdata[0];
        mhtm_pkg::REG_LOW_LIMIT:         cfg.low_limit         <= pwdata;
        mhtm_pkg::REG_HIGH_LIMIT:        cfg.high_limit        <= pwdata;
        mhtm_pkg::REG_HISTORY_LENGTH:
          cfg.history_length <= pwdata[mhtm_pkg::HIST_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mhtm_pkg::REG_MONITOR_ENABLE:    prdata = 64'(cfg.monitor_enable);
      mhtm_pkg::REG_VALUE_KIND:        prdata = 64'(cfg.value_kind);
      mhtm_pkg::REG_CHECK_LOW_ENABLE:  prdata = 64'(cfg.check_low_enable);
      mhtm_pkg::REG_CHECK_HIGH_ENABLE: prdata = 64'(cfg.check_high_enable);
      mhtm_pkg::REG_LOW_LIMIT:         prdata = cfg.low_limit;
      mhtm_pkg::REG_HIGH_LIMIT:        prdata = cfg.high_limit;
      mhtm_pkg::REG_HISTORY_LENGTH:    prdata = 64'(cfg.history_length);
      default:                         prdata = '0;
    endcase
  end

endmodule

/* rtl/core/mhtm_front.sv */
// mhtm_front: accepts samples, keeps ring pointer and fill count, gives the
// threshold verdict and plans the trend reads; depends on mhtm_pkg

module mhtm_front #(
  parameter int HISTORY_DEPTH = mhtm_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  mhtm_pkg::cfg_t                                     cfg,
  input  logic                                               push,
  output logic                                               full,
  input  logic [mhtm_pkg::SAMPLE_W-1:0]                      sample_value,
  input  logic                                               q_full,
  output logic                                               q_push,
  output logic [mhtm_pkg::item_width(HISTORY_DEPTH)-1:0]     q_data
);

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W = (CNT_W > mhtm_pkg::HIST_LEN_W) ? CNT_W : mhtm_pkg::HIST_LEN_W;

  logic [PTR_W-1:0] wpos, wpos_next;
  logic [CNT_W-1:0] fill, fill_next;

  logic [CMP_W-1:0] hl_ext;
  logic [CNT_W-1:0] len, wp_inc, fc, fill_upd;
  logic [PTR_W-1:0] wp, wpos_adv, start, f_idx, g_idx;
  logic [CNT_W:0]   last_sum;
  logic             c_two, need_trend, over;
  mhtm_pkg::item_ctl_t ctl;

  assign full   = q_full;
  assign q_push = push && !q_full;

  // effective ring length: zero acts as one, saturate at the depth
  always_comb begin
    hl_ext = CMP_W'(cfg.history_length);
    if (hl_ext == '0) begin
      len = CNT_W'(1);
    end else if (hl_ext > CMP_W'(HISTORY_DEPTH)) begin
      len = CNT_W'(HISTORY_DEPTH);
    end else begin
      len = CNT_W'(hl_ext);
    end
  end

  always_comb begin
    wp       = (CNT_W'(wpos) >= len) ? '0 : wpos;
    fc       = (fill > len) ? len : fill;
    wp_inc   = CNT_W'(wp) + CNT_W'(1);
    wpos_adv = (wp_inc == len) ? '0 : PTR_W'(wp_inc);
    fill_upd = (fc < len) ? fc + CNT_W'(1) : fc;

    // trend window: oldest up to three kept samples
    need_trend = (cfg.value_kind == mhtm_pkg::KIND_NUMBER) && (fill_upd >= CNT_W'(2));
    c_two      = (fill_upd >= CNT_W'(3));
    start      = (fill_upd == len) ? wpos_adv : '0;
    f_idx      = start;
    last_sum   = (CNT_W+1)'(start) + (c_two ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
    if (last_sum >= (CNT_W+1)'(len)) begin
      g_idx = PTR_W'(last_sum - (CNT_W+1)'(len));
    end else begin
      g_idx = PTR_W'(last_sum);
    end

    over = ((cfg.value_kind == mhtm_pkg::KIND_NUMBER) ||
            (cfg.value_kind == mhtm_pkg::KIND_ENUM)) &&
           ((cfg.check_low_enable && (sample_value < cfg.low_limit)) ||
            (cfg.check_high_enable && (sample_value > cfg.high_limit)));

    if (cfg.monitor_enable) begin
      ctl.wr_en      = 1'b1;
      ctl.need_trend = need_trend;
      ctl.c_two      = c_two;
      ctl.status     = over ? mhtm_pkg::STATUS_THRESHOLD : mhtm_pkg::STATUS_OK;
      ctl.fill       = mhtm_pkg::FILL_W'(fill_upd);
      wpos_next      = wpos_adv;
      fill_next      = fill_upd;
    end else begin
      ctl.wr_en      = 1'b0;
      ctl.need_trend = 1'b0;
      ctl.c_two      = 1'b0;
      ctl.status     = mhtm_pkg::STATUS_DISABLED;
      ctl.fill       = mhtm_pkg::FILL_W'(fill);
      wpos_next      = wpos;
      fill_next      = fill;
    end
  end

  assign q_data = {sample_value, wp, f_idx, g_idx, ctl};

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos <= '0;
      fill <= '0;
    end else if (q_push) begin
      wpos <= wpos_next;
      fill <= fill_next;
    end
  end

endmodule

/* rtl/core/mhtm_queue.sv */
// mhtm_queue: short fifo between front and back parts
// depends on mhtm_pkg (QUEUE_DEPTH)

module mhtm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int IDX_W = $clog2(mhtm_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(mhtm_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [mhtm_pkg::QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(mhtm_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == IDX_W'(mhtm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == IDX_W'(mhtm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && full && !rd))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd && empty))
    else $error("queue read while empty");
`endif

endmodule

/* rtl/core/mhtm_back.sv */
// mhtm_back: history memory and trend pipeline, output register
// depends on mhtm_pkg (item layout, status and trend codes)

module mhtm_back #(
  parameter int HISTORY_DEPTH = mhtm_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               q_empty,
  input  logic [mhtm_pkg::item_width(HISTORY_DEPTH)-1:0]     q_data,
  output logic                                               q_pop,
  output logic                                               empty,
  input  logic                                               pop,
  output logic [1:0]                                         status,
  output logic [1:0]                                         trend_class,
  output logic [mhtm_pkg::FILL_W-1:0]                        fill_level
);

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int SW    = mhtm_pkg::SAMPLE_W;

  logic [SW-1:0]    hist_mem [HISTORY_DEPTH];

  logic [SW-1:0]       h_sample;
  logic [PTR_W-1:0]    h_wr_addr, h_f_idx, h_g_idx;
  mhtm_pkg::item_ctl_t h_ctl;

  logic                adv;

  // stage 1: read data of the two window ends
  logic                s1_valid;
  logic [SW-1:0]       s1_sample, s1_rd_f, s1_rd_g;
  logic                s1_f_byp, s1_g_byp;
  mhtm_pkg::item_ctl_t s1_ctl;

  // stage 2: difference, direction and floored base value
  logic                s2_valid;
  logic [SW-1:0]       s2_diff, s2_m;
  logic                s2_inc;
  mhtm_pkg::item_ctl_t s2_ctl;

  // output register
  logic                o_valid;
  mhtm_pkg::status_t   o_status;
  mhtm_pkg::trend_t    o_trend;
  logic [mhtm_pkg::FILL_W-1:0] o_fill;

  logic [SW-1:0]       f_val, g_val;
  logic [SW+4:0]       lhs, rhs;
  mhtm_pkg::trend_t    trend;

  assign {h_sample, h_wr_addr, h_f_idx, h_g_idx, h_ctl} = q_data;

  // whole pipeline moves unless the output register is held
  assign adv   = !o_valid || pop;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (h_ctl.wr_en) begin
        hist_mem[h_wr_addr] <= h_sample;
      end
      s1_rd_f <= hist_mem[h_f_idx];
      s1_rd_g <= hist_mem[h_g_idx];
    end
  end

  always_comb begin
    f_val = s1_f_byp ? s1_sample : s1_rd_f;
    g_val = s1_g_byp ? s1_sample : s1_rd_g;
  end

  // 20*diff < c*max(20, f), diff scaled by shifts
  always_comb begin
    lhs = ((SW+5)'(s2_diff) << 4) + ((SW+5)'(s2_diff) << 2);
    rhs = s2_ctl.c_two ? ((SW+5)'(s2_m) << 1) : (SW+5)'(s2_m);
    if (!s2_ctl.need_trend || (lhs < rhs)) begin
      trend = mhtm_pkg::TREND_STABLE;
    end else if (s2_inc) begin
      trend = mhtm_pkg::TREND_INCREASING;
    end else begin
      trend = mhtm_pkg::TREND_DECREASING;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample <= h_sample;
      s1_ctl    <= h_ctl;
      s1_f_byp  <= h_ctl.wr_en && (h_f_idx == h_wr_addr);
      s1_g_byp  <= h_ctl.wr_en && (h_g_idx == h_wr_addr);

      s2_ctl  <= s1_ctl;
      s2_inc  <= (g_val > f_val);
      s2_diff <= (g_val >= f_val) ? g_val - f_val : f_val - g_val;
      s2_m    <= (f_val > mhtm_pkg::TREND_FLOOR) ? f_val : mhtm_pkg::TREND_FLOOR;

      o_status <= s2_ctl.status;
      o_trend  <= trend;
      o_fill   <= s2_ctl.fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= !q_empty;
      s2_valid <= s1_valid;
      o_valid  <= s2_valid;
    end
  end

  assign empty       = !o_valid;
  assign status      = o_status;
  assign trend_class = o_trend;
  assign fill_level  = o_fill;

`ifndef SYNTHESIS
  a_disabled_stable: assert property (@(posedge clk) disable iff (rst)
    (o_valid && (o_status == mhtm_pkg::STATUS_DISABLED)) |-> (o_trend == mhtm_pkg::TREND_STABLE))
    else $error("dropped sample reported a trend");

  a_short_history_stable: assert property (@(posedge clk) disable iff (rst)
    (o_valid && (o_fill < mhtm_pkg::FILL_W'(2))) |-> (o_trend == mhtm_pkg::TREND_STABLE))
    else $error("trend reported with fewer than two samples");

  a_held_result_kept: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !pop) |=> (o_valid && $stable(o_fill) && $stable(o_trend)))
    else $error("waiting result lost or changed");
`endif

endmodule

/* rtl/core/metric_history_threshold_trend_monitor.sv */
// metric_history_threshold_trend_monitor: top level of the metric monitor
// depends on mhtm_pkg, mhtm_regs, mhtm_front, mhtm_queue, mhtm_back

// Each pushed sample gives exactly one result: a threshold status on the
// sample (ok, exceeded, or dropped when the monitor is disabled), a trend
// class from the oldest up to three kept samples, and the fill level after
// the sample. The front part accepts one transaction per cycle unless the
// queue is full, updates the ring pointer and fill count, and queues the
// planned memory accesses; the back part writes the history memory and
// reads both window ends in the same cycle, then needs two more stages for
// the trend compare. With no stall a sample passes the queue, memory read
// stage, difference stage and output register before its result can be
// popped, and the block sustains one transaction per cycle; full rises
// only when the four-entry queue fills behind a result that is not popped.
// No clearing pass follows reset. The user must write registers over the
// apb-style port only while no transaction is in flight (not enforced).

module metric_history_threshold_trend_monitor #(
  parameter int HISTORY_DEPTH = mhtm_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mhtm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mhtm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mhtm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  // sample side
  input  logic                             push,
  output logic                             full,
  input  logic [mhtm_pkg::SAMPLE_W-1:0]    sample_value,
  // result side
  output logic                             empty,
  input  logic                             pop,
  output logic [1:0]                       status,
  output logic [1:0]                       trend_class,
  output logic [mhtm_pkg::FILL_W-1:0]      fill_level
);

  // one queued transaction: sample, write address, window ends, control
  localparam int ITEM_W = mhtm_pkg::item_width(HISTORY_DEPTH);

  mhtm_pkg::cfg_t    cfg;
  logic              q_push, q_full, q_pop, q_empty;
  logic [ITEM_W-1:0] q_wdata, q_rdata;

  // register file, read back at any time
  mhtm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: threshold verdict, ring bookkeeping, trend window addresses
  mhtm_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .sample_value (sample_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  // decoupling queue so either side can stall alone
  mhtm_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: history memory, trend pipeline, output register
  mhtm_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .trend_class (trend_class),
    .fill_level  (fill_level)
  );

endmodule
